// ===== rtl/ssi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int STATUS_W   = 3;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // configuration register indexes
    localparam logic REG_VALUE_LIMIT = 1'b0;
    localparam logic REG_SIZE_LIMIT  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd5;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/ssi_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssi_store (
    input  wire logic                          i_clk,
    input  wire ssi_pkg::t_mem_req             i_req,
    output logic [ssi_pkg::VALUE_BITS-1:0]     o_rdata
);
    import ssi_pkg::*;

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_set_insert_core.sv =====
// Sorted, duplicate-free set of up to 64 values with insert and indexed read.
// Input channel: i_in_valid / o_in_stall carry one word of i_command, i_value
// and i_index. Output channel: o_out_valid / i_out_stall carry o_status,
// o_read_value and o_count; every input word gives exactly one output word.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data (index 0 value limit, index 1
// size limit); the user must write only while the block is idle (not enforced).
// One word is in work at a time; o_in_stall is high until it is finished, and
// the next word can be taken in the cycle after the result is registered.
// Rejected inserts and out-of-range reads pass S_RESP, in-range reads S_RDAT first.
// An accepted insert runs a binary search of S_SRD/S_SCMP probes (up to 6
// probes) ended by S_SRD, a duplicate check in S_DRD/S_DCMP (skipped at
// position 0), the shift of the larger entries through the table at one entry
// a cycle, the last pending write, the new value's write, and S_RESP's result.
// The table's single read port and single write port bound the shift rate.
// Reset (synchronous, active low) empties the set and restores the limits;
// o_in_stall is high while reset is held; the table contents are not cleared.
// When the receiver stalls, the finished word waits in the output register;
// the next input word may be taken and worked on meanwhile, but its result
// holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_command,
    input  wire logic [ssi_pkg::VALUE_BITS-1:0]    i_value,
    input  wire logic [ssi_pkg::ADDR_W-1:0]        i_index,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [ssi_pkg::STATUS_W-1:0]           o_status,
    output logic [ssi_pkg::VALUE_BITS-1:0]         o_read_value,
    output logic [ssi_pkg::CNT_W-1:0]              o_count,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [ssi_pkg::VALUE_BITS-1:0]    i_cfg_data
);
    import ssi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRD   = 8'b0000_0010,
        S_SCMP  = 8'b0000_0100,
        S_DRD   = 8'b0000_1000,
        S_DCMP  = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_RESP  = 8'b0100_0000,
        S_RDAT  = 8'b1000_0000
    } t_state;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_value_limit;
    logic [CNT_W-1:0]       r_size_limit;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [VALUE_BITS-1:0]  r_value, n_value;
    logic [CNT_W-1:0]       r_lo, n_lo;
    logic [CNT_W-1:0]       r_hi, n_hi;
    logic [CNT_W-1:0]       r_mid, n_mid;
    logic [CNT_W-1:0]       r_ptr, n_ptr;
    logic                   r_wpend, n_wpend;
    logic [ADDR_W-1:0]      r_waddr, n_waddr;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [VALUE_BITS-1:0]  r_out_value;
    logic [CNT_W-1:0]       r_out_count;

    logic [CNT_W-1:0]       lim;
    logic [CNT_W-1:0]       mid;
    logic [VALUE_BITS-1:0]  rdata;
    logic                   in_acc;
    logic                   out_free;
    t_mem_req               req;

    ssi_store u_store (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    assign lim      = (r_size_limit < CAP_C) ? r_size_limit : CAP_C;
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall   = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;
    assign o_count      = r_out_count;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_value  = r_value;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_ptr    = r_ptr;
        n_wpend  = r_wpend;
        n_waddr  = r_waddr;
        n_status = r_status;
        req      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value = i_value;
                    if (i_command == CMD_READ) begin
                        if (CNT_W'(i_index) < r_count) begin
                            req.re    = 1'b1;
                            req.raddr = i_index;
                            n_status  = ST_READ_OK;
                            n_state   = S_RDAT;
                        end else begin
                            n_status = ST_BEYOND;
                            n_state  = S_RESP;
                        end
                    end else if (i_value > r_value_limit) begin
                        n_status = ST_ABOVE;
                        n_state  = S_RESP;
                    end else if (r_count >= lim) begin
                        n_status = ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_lo < r_hi) begin
                    req.re    = 1'b1;
                    req.raddr = mid[ADDR_W-1:0];
                    n_mid     = mid;
                    n_state   = S_SCMP;
                end else if (r_lo != '0) begin
                    n_state = S_DRD;
                end else begin
                    n_ptr   = r_count;
                    n_wpend = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SCMP: begin
                if (rdata <= r_value) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRD;
            end
            S_DRD: begin
                // r_lo holds the insert position; check the entry below it
                req.re    = 1'b1;
                req.raddr = ADDR_W'(r_lo - CNT_W'(1));
                n_state   = S_DCMP;
            end
            S_DCMP: begin
                if (rdata == r_value) begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_RESP;
                end else begin
                    n_ptr   = r_count;
                    n_wpend = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // read entry ptr-1 while the previously read word lands one up
                if (r_wpend) begin
                    req.we    = 1'b1;
                    req.waddr = r_waddr;
                    req.wdata = rdata;
                end
                if (r_ptr > r_lo) begin
                    req.re    = 1'b1;
                    req.raddr = ADDR_W'(r_ptr - CNT_W'(1));
                    n_waddr   = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr - CNT_W'(1);
                    n_wpend   = 1'b1;
                end else if (r_wpend) begin
                    n_wpend = 1'b0;
                end else begin
                    req.we    = 1'b1;
                    req.waddr = r_lo[ADDR_W-1:0];
                    req.wdata = r_value;
                    n_count   = r_count + CNT_W'(1);
                    n_status  = ST_INSERTED;
                    n_state   = S_RESP;
                end
            end
            S_RDAT: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_value_limit <= '1;
            r_size_limit  <= CAP_C;
            r_wpend       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_VALUE_LIMIT) begin
                    r_value_limit <= i_cfg_data;
                end else begin
                    r_size_limit <= i_cfg_data[CNT_W-1:0];
                end
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_ptr    <= n_ptr;
        r_waddr  <= n_waddr;
        r_status <= n_status;
        if (r_state == S_RESP && out_free) begin
            r_out_status <= r_status;
            r_out_value  <= (r_status == ST_READ_OK) ? rdata : '0;
            r_out_count  <= r_count;
        end
    end

    // count never exceeds the table depth
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    // the pending shift write always targets the slot just above the read
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_wpend) |-> (CNT_W'(r_waddr) == r_ptr + CNT_W'(1)))
        else $error("shift write address out of step");

    // search window stays ordered and within the count
    a_search_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRD || r_state == S_SCMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search window broken");

    // final insert write bumps the count by one
    a_insert_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !r_wpend && r_ptr <= r_lo)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance count");

    // a finished word never overwrites one still waiting at the output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_state == S_RESP) |=> (r_state == S_RESP))
        else $error("result left while output blocked");

endmodule

`default_nettype wire
